/* design/pcl_pkg.sv */
// Shared types, widths and constants of the perceptron classifier.
package pcl_pkg;

    localparam int X_W      = 16;             // feature, signed Q4.12
    localparam int W_W      = 32;             // weight and score, signed Q16.16
    localparam int RATE_W   = 16;             // learning rate, unsigned Q8.8
    localparam int MODE_W   = 2;
    localparam int LABEL_W  = 2;
    localparam int E_W      = 3;              // error factor, -3 .. 1
    localparam int RE_W     = RATE_W + 1 + E_W;
    localparam int PROD_W   = W_W + X_W;
    localparam int ACC_W    = PROD_W + 4;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int MAX_FEAT = 8;

    localparam int SCORE_SHIFT = 12;
    localparam int UPD_SHIFT   = 4;

    localparam logic signed [ACC_W-1:0]  SCORE_HALF = ACC_W'(2048);
    localparam logic signed [PROD_W-1:0] UPD_HALF   = PROD_W'(8);

    // The bias lane sees a constant feature of 1.0 in Q4.12.
    localparam logic signed [X_W-1:0] ONE_Q4_12 = 16'sd4096;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-W_W+1){1'b0}}, {(W_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-W_W+1){1'b1}}, {(W_W-1){1'b0}}};

    localparam logic [MODE_W-1:0] MODE_HEAVISIDE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROSENBLATT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REGRESSION = 2'd2;

    localparam logic signed [LABEL_W-1:0] DEC_POS  = 2'sb01;
    localparam logic signed [LABEL_W-1:0] DEC_ZERO = 2'sb00;
    localparam logic signed [LABEL_W-1:0] DEC_NEG  = 2'sb11;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_RATE = 1'b1;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

    typedef struct packed {
        logic load;     // capture the feature
        logic mul;      // weight times feature
        logic umul;     // step times feature
        logic uadd;     // apply the weight update
    } t_lane_ctrl;

    typedef struct packed {
        logic sum;      // add up the lane products
        logic dec;      // round, saturate and classify
        logic rate;     // form the update step and the mismatch flag
    } t_merge_ctrl;

    function automatic logic signed [W_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [W_W-1:0] r;
        if (v > SAT_HI) begin
            r = {1'b0, {(W_W-1){1'b1}}};
        end else if (v < SAT_LO) begin
            r = {1'b1, {(W_W-1){1'b0}}};
        end else begin
            r = $signed(v[W_W-1:0]);
        end
        return r;
    endfunction

endpackage

/* design/pcl_if.sv */
// Handshake channels for feature words and classification result words.
interface pcl_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
    logic signed [15:0] feature_4;
    logic signed [15:0] feature_5;
    logic signed [15:0] feature_6;
    logic signed [15:0] feature_7;
    logic signed [1:0]  label;

    modport source (output valid, action, feature_0, feature_1, feature_2, feature_3,
                    feature_4, feature_5, feature_6, feature_7, label, input ready);
    modport sink (input valid, action, feature_0, feature_1, feature_2, feature_3,
                  feature_4, feature_5, feature_6, feature_7, label, output ready);
endinterface

interface pcl_out_if;
    logic               valid;
    logic               ready;
    logic signed [1:0]  decision;
    logic signed [31:0] score;
    logic               updated;

    modport source (output valid, decision, score, updated, input ready);
    modport sink (input valid, decision, score, updated, output ready);
endinterface

/* design/pcl_lane.sv */
// One weight lane: holds a weight, multiplies it by its feature and applies updates.
module pcl_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pcl_pkg::t_lane_ctrl                 i_ctrl,
    input  logic signed [pcl_pkg::X_W-1:0]      i_x,
    input  logic signed [pcl_pkg::RE_W-1:0]     i_re,
    output logic signed [pcl_pkg::PROD_W-1:0]   o_prod,
    output logic                                o_chg
);
    import pcl_pkg::*;

    logic signed [W_W-1:0]       r_w;
    logic signed [W_W-1:0]       n_w;
    logic signed [X_W-1:0]       r_x;
    logic signed [PROD_W-1:0]    r_prod;
    logic                        r_chg;

    logic signed [PROD_W-1:0]    w_wprod;
    logic signed [RE_W+X_W-1:0]  w_dprod;
    logic signed [PROD_W-1:0]    w_shf;
    logic signed [ACC_W-1:0]     w_sum;

    assign w_wprod = r_w * r_x;
    assign w_dprod = i_re * r_x;

    // Step product is in units of 2^-20; round half up to Q16.16.
    assign w_shf = (r_prod + UPD_HALF) >>> UPD_SHIFT;
    assign w_sum = ACC_W'(r_w) + ACC_W'(w_shf);
    assign n_w   = sat32(w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= '0;
            r_chg <= 1'b0;
        end else if (i_ctrl.uadd) begin
            r_w   <= n_w;
            r_chg <= (n_w != r_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_x;
        end
        if (i_ctrl.mul) begin
            r_prod <= w_wprod;
        end else if (i_ctrl.umul) begin
            r_prod <= PROD_W'(w_dprod);
        end
    end

    assign o_prod = r_prod;
    assign o_chg  = r_chg;

endmodule

/* design/pcl_merge.sv */
// Merge stage: sums the lane products, classifies the score and forms the update step.
module pcl_merge #(
    parameter int LANES = 9
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pcl_pkg::t_merge_ctrl                 i_ctrl,
    input  logic signed [pcl_pkg::PROD_W-1:0]    i_prod [LANES],
    input  logic [pcl_pkg::MODE_W-1:0]           i_mode,
    input  logic [pcl_pkg::RATE_W-1:0]           i_rate,
    input  logic signed [pcl_pkg::LABEL_W-1:0]   i_label,
    input  logic                                 i_action,
    output logic signed [pcl_pkg::W_W-1:0]       o_score,
    output logic signed [pcl_pkg::LABEL_W-1:0]   o_decision,
    output logic signed [pcl_pkg::RE_W-1:0]      o_re,
    output logic                                 o_upd
);
    import pcl_pkg::*;

    logic signed [ACC_W-1:0]    r_acc;
    logic signed [W_W-1:0]      r_score;
    logic signed [LABEL_W-1:0]  r_dec;
    logic signed [RE_W-1:0]     r_re;
    logic                       r_upd;

    logic signed [ACC_W-1:0]    w_sum;
    logic signed [ACC_W-1:0]    w_rnd;
    logic signed [W_W-1:0]      w_score;
    logic signed [LABEL_W-1:0]  w_dec;
    logic signed [E_W-1:0]      w_e;
    logic signed [RE_W-1:0]     w_re;
    logic                       w_upd;

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            w_sum = w_sum + ACC_W'(i_prod[i]);
        end
    end

    // The sum is in units of 2^-28; round half up to Q16.16.
    assign w_rnd   = (r_acc + SCORE_HALF) >>> SCORE_SHIFT;
    assign w_score = sat32(w_rnd);

    always_comb begin
        unique case (i_mode)
            MODE_HEAVISIDE: begin
                if (w_score > 0) begin
                    w_dec = DEC_POS;
                end else if (w_score < 0) begin
                    w_dec = DEC_NEG;
                end else begin
                    w_dec = DEC_ZERO;
                end
            end
            MODE_ROSENBLATT: begin
                w_dec = (w_score > 0) ? DEC_POS : DEC_ZERO;
            end
            default: begin
                w_dec = DEC_ZERO;
            end
        endcase
    end

    always_comb begin
        if (i_mode == MODE_HEAVISIDE) begin
            w_e = E_W'(i_label);
        end else begin
            w_e = E_W'(i_label) - E_W'(r_dec);
        end
    end

    assign w_re  = $signed({1'b0, i_rate}) * w_e;
    assign w_upd = i_action && (r_dec != i_label)
                   && ((i_mode == MODE_HEAVISIDE) || (i_mode == MODE_ROSENBLATT));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sum) begin
            r_acc <= w_sum;
        end
        if (i_ctrl.dec) begin
            r_score <= w_score;
            r_dec   <= w_dec;
        end
        if (i_ctrl.rate) begin
            r_re <= w_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd <= 1'b0;
        end else if (i_ctrl.rate) begin
            r_upd <= w_upd;
        end
    end

    assign o_score    = r_score;
    assign o_decision = r_dec;
    assign o_re       = r_re;
    assign o_upd      = r_upd;

endmodule

/* design/perceptron_classify_train.sv */
// Top level of the perceptron classifier with on-line training.
//
// Feature words arrive on i_item (valid/ready); each gives one result word on
// o_result. A word carries up to eight Q4.12 features, a label and an action
// bit; the result carries the score (Q16.16, saturated), the decision and
// whether a train word changed the weights. Mode and learning rate sit behind
// an APB port at byte addresses 0 and 4; pready is always high.
//
// One lane per weight (the bias lane sees a constant feature of 1.0) forms its
// product in parallel; a merge stage sums, rounds, saturates and classifies.
// From the accepting edge to o_result.valid a word passes the states multiply,
// sum, classify, step, step multiply, weight add (only when an update runs)
// and output load. The weights of one word feed the next, so words are
// handled one at a time; i_item.ready is high only while the sequencer is
// idle, so a new word is taken only after the previous result is loaded.
// A result waiting in the output register does not stop the next word; when
// the receiver stalls longer, the finished word waits in the output stage.
// Reset clears all weights, sets mode to Heaviside and the rate to 1.0.
module perceptron_classify_train #(
    parameter int FEATURES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pcl_in_if.sink                            i_item,
    pcl_out_if.source                         o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcl_pkg::PADDR_W-1:0]       paddr,
    input  logic [pcl_pkg::PDATA_W-1:0]       pwdata,
    output logic [pcl_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import pcl_pkg::*;

    localparam int LANES = FEATURES + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_RATE = 3'd4;
    localparam logic [2:0] S_UMUL = 3'd5;
    localparam logic [2:0] S_UADD = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic [MODE_W-1:0]          r_mode;
    logic [RATE_W-1:0]          r_rate;
    logic                       r_action;
    logic signed [LABEL_W-1:0]  r_label;

    logic                       r_out_valid;
    logic signed [LABEL_W-1:0]  r_out_dec;
    logic signed [W_W-1:0]      r_out_score;
    logic                       r_out_upd;

    logic                       w_accept;
    logic                       w_out_free;
    logic                       w_cfg_wr;
    t_lane_ctrl                 w_lane_ctrl;
    t_merge_ctrl                w_merge_ctrl;

    logic signed [X_W-1:0]      w_feat [MAX_FEAT];
    logic signed [PROD_W-1:0]   w_prod [LANES];
    logic [LANES-1:0]           w_chg;

    logic signed [W_W-1:0]      w_score;
    logic signed [LABEL_W-1:0]  w_dec;
    logic signed [RE_W-1:0]     w_re;
    logic                       w_upd;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HEAVISIDE;
            r_rate <= RATE_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_MODE: r_mode <= pwdata[MODE_W-1:0];
                REG_RATE: r_rate <= pwdata[RATE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MODE: prdata = PDATA_W'(r_mode);
            REG_RATE: prdata = PDATA_W'(r_rate);
        endcase
    end

    // Sequencer.
    assign i_item.ready = (r_state == S_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_out_free   = !r_out_valid || o_result.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_MUL;
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_DEC;
            S_DEC:  n_state = S_RATE;
            S_RATE: n_state = S_UMUL;
            S_UMUL: n_state = w_upd ? S_UADD : S_OUT;
            S_UADD: n_state = S_OUT;
            S_OUT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_item.action;
            r_label  <= i_item.label;
        end
    end

    assign w_lane_ctrl.load  = w_accept;
    assign w_lane_ctrl.mul   = (r_state == S_MUL);
    assign w_lane_ctrl.umul  = (r_state == S_UMUL) && w_upd;
    assign w_lane_ctrl.uadd  = (r_state == S_UADD);

    assign w_merge_ctrl.sum  = (r_state == S_SUM);
    assign w_merge_ctrl.dec  = (r_state == S_DEC);
    assign w_merge_ctrl.rate = (r_state == S_RATE);

    assign w_feat[0] = i_item.feature_0;
    assign w_feat[1] = i_item.feature_1;
    assign w_feat[2] = i_item.feature_2;
    assign w_feat[3] = i_item.feature_3;
    assign w_feat[4] = i_item.feature_4;
    assign w_feat[5] = i_item.feature_5;
    assign w_feat[6] = i_item.feature_6;
    assign w_feat[7] = i_item.feature_7;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic signed [X_W-1:0] w_x;
        if (k == 0) begin : g_bias
            assign w_x = ONE_Q4_12;
        end else begin : g_feat
            assign w_x = w_feat[k-1];
        end
        pcl_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_lane_ctrl),
            .i_x     (w_x),
            .i_re    (w_re),
            .o_prod  (w_prod[k]),
            .o_chg   (w_chg[k])
        );
    end

    pcl_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_merge_ctrl),
        .i_prod     (w_prod),
        .i_mode     (r_mode),
        .i_rate     (r_rate),
        .i_label    (r_label),
        .i_action   (r_action),
        .o_score    (w_score),
        .o_decision (w_dec),
        .o_re       (w_re),
        .o_upd      (w_upd)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_dec   <= w_dec;
            r_out_score <= w_score;
            r_out_upd   <= w_upd && (|w_chg);
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.decision = r_out_dec;
    assign o_result.score    = r_out_score;
    assign o_result.updated  = r_out_upd;

    // Training never happens in the regression and spare modes.
    a_no_upd_regr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && r_mode[1]) |-> !o_result.updated)
        else $error("weight update reported in regression mode");

    // The regression and spare modes always give a zero decision.
    a_regr_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && r_mode[1]) |-> (o_result.decision == DEC_ZERO))
        else $error("nonzero decision in regression mode");

    // The weight add runs only for a word that needs an update.
    a_uadd_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UADD) |-> w_upd)
        else $error("weight update without mismatch");

    // An accepted word starts the product stage on the next cycle.
    a_accept_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MUL))
        else $error("sequencer did not start after accepting a word");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the perceptron classifier: directed rows, then random training passes.
`timescale 1ns / 1ps

module tb_top;
    import pcl_pkg::*;

    localparam int     N_DIRECTED = 24;
    localparam int     N_PHASES   = 12;
    localparam int     PHASE_LEN  = 140;
    localparam int     HOLD_PHASE = 5;
    localparam int     HOLD_LEN   = 300;
    localparam int     LIMIT      = 400000;
    localparam longint W_MAX      = 64'sh7fff_ffff;
    localparam longint W_MIN      = -64'sh8000_0000;

    localparam logic                      ACT_CLASSIFY = 1'b0;
    localparam logic                      ACT_TRAIN    = 1'b1;
    localparam logic [MODE_W-1:0]         MODE_SPARE   = 2'd3;
    localparam logic signed [LABEL_W-1:0] LABEL_OOR    = 2'sb10;

    typedef struct packed {
        logic                      action;
        logic [MAX_FEAT*X_W-1:0]   x;
        logic signed [LABEL_W-1:0] label;
    } t_word;

    typedef struct packed {
        logic signed [LABEL_W-1:0] decision;
        logic signed [W_W-1:0]     score;
        logic                      updated;
    } t_verdict;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [RATE_W-1:0]         rate;
        logic                      action;
        logic [MAX_FEAT*X_W-1:0]   x;
        logic signed [LABEL_W-1:0] label;
        logic                      known;
        logic signed [LABEL_W-1:0] decision;
        logic signed [W_W-1:0]     score;
        logic                      updated;
    } t_row;

    // Rows with known set carry an expectation that follows from the cleared
    // weights and earlier rows; all others are checked against the predictor.
    t_row directed_rows [N_DIRECTED] = '{
        '{MODE_HEAVISIDE, RATE_RESET, ACT_CLASSIFY, {8{16'h7fff}}, DEC_POS, 1'b1,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_HEAVISIDE, RATE_RESET, ACT_CLASSIFY, {8{16'h8000}}, DEC_NEG, 1'b1,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_HEAVISIDE, RATE_RESET, ACT_TRAIN, {8{16'h1000}}, DEC_POS, 1'b1,
          DEC_ZERO, 32'sd0, 1'b1},
        '{MODE_HEAVISIDE, RATE_RESET, ACT_CLASSIFY, {8{16'h1000}}, DEC_POS, 1'b1,
          DEC_POS, 32'sd589824, 1'b0},
        '{MODE_HEAVISIDE, RATE_RESET, ACT_TRAIN, {8{16'h1000}}, DEC_POS, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_HEAVISIDE, RATE_RESET, ACT_TRAIN, {8{16'h8000}}, DEC_NEG, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_HEAVISIDE, RATE_RESET, ACT_TRAIN, {8{16'h8000}}, DEC_POS, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_HEAVISIDE, RATE_RESET, ACT_TRAIN, {8{16'h0800}}, LABEL_OOR, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_HEAVISIDE, RATE_RESET, ACT_TRAIN, 128'd0, DEC_ZERO, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_HEAVISIDE, 16'd0, ACT_TRAIN, {8{16'h1000}}, DEC_NEG, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_HEAVISIDE, 16'hffff, ACT_TRAIN, {8{16'h7fff}}, DEC_POS, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_HEAVISIDE, 16'hffff, ACT_TRAIN, {8{16'h7fff}}, DEC_POS, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_HEAVISIDE, 16'hffff, ACT_CLASSIFY, {8{16'h7fff}}, DEC_POS, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_HEAVISIDE, 16'hffff, ACT_TRAIN, {8{16'h8000}}, DEC_POS, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_HEAVISIDE, 16'hffff, ACT_TRAIN, {8{16'h7fff}}, DEC_NEG, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_ROSENBLATT, RATE_RESET, ACT_TRAIN, {8{16'h1000}}, DEC_ZERO, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_ROSENBLATT, RATE_RESET, ACT_TRAIN, {8{16'h1000}}, DEC_POS, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_ROSENBLATT, RATE_RESET, ACT_TRAIN, {8{16'hf000}}, DEC_POS, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_ROSENBLATT, RATE_RESET, ACT_TRAIN, {8{16'h1000}}, LABEL_OOR, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_ROSENBLATT, RATE_RESET, ACT_CLASSIFY, 128'd0, DEC_ZERO, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_REGRESSION, RATE_RESET, ACT_TRAIN, {8{16'h1000}}, DEC_POS, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_REGRESSION, RATE_RESET, ACT_CLASSIFY, {8{16'h8000}}, DEC_NEG, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_SPARE, RATE_RESET, ACT_TRAIN, {8{16'h7fff}}, DEC_POS, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0},
        '{MODE_SPARE, RATE_RESET, ACT_CLASSIFY, {4{16'h7fff, 16'h8000}}, DEC_ZERO, 1'b0,
          DEC_ZERO, 32'sd0, 1'b0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    pcl_in_if  item_if();
    pcl_out_if result_if();

    perceptron_classify_train dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor state: bias in slot 0, then one weight per feature.
    logic signed [W_W-1:0] weight [0:MAX_FEAT];
    logic [MODE_W-1:0]     cfg_mode;
    logic [RATE_W-1:0]     cfg_rate;

    t_verdict verdict_q [$];
    t_verdict want_v;
    int       failures = 0;
    int       cycle_count = 0;
    bit       quiet = 1'b0;
    bit       hold_request = 1'b0;

    always #10 i_clk = ~i_clk;

    function automatic longint clip32(input longint v);
        if (v > W_MAX) begin
            return W_MAX;
        end else if (v < W_MIN) begin
            return W_MIN;
        end
        return v;
    endfunction

    // Scores one word against the current weights and applies the learning rule.
    function automatic t_verdict classify_and_learn(input t_word w);
        longint                    acc;
        longint                    sc;
        longint                    e;
        longint                    nw;
        longint                    xi;
        logic signed [LABEL_W-1:0] dec;
        logic                      changed;
        t_verdict                  v;
        changed = 1'b0;
        acc = longint'(weight[0]) * 4096;
        for (int i = 0; i < MAX_FEAT; i++) begin
            acc += longint'(weight[i+1]) * longint'($signed(w.x[X_W*i +: X_W]));
        end
        sc = clip32((acc + 2048) >>> SCORE_SHIFT);
        case (cfg_mode)
            MODE_HEAVISIDE: begin
                dec = (sc > 0) ? DEC_POS : ((sc < 0) ? DEC_NEG : DEC_ZERO);
            end
            MODE_ROSENBLATT: begin
                dec = (sc > 0) ? DEC_POS : DEC_ZERO;
            end
            default: begin
                dec = DEC_ZERO;
            end
        endcase
        if (w.action == ACT_TRAIN && (cfg_mode == MODE_HEAVISIDE || cfg_mode == MODE_ROSENBLATT)
            && dec != w.label) begin
            if (cfg_mode == MODE_HEAVISIDE) begin
                e = longint'($signed(w.label));
            end else begin
                e = longint'($signed(w.label)) - longint'(dec);
            end
            nw = clip32(longint'(weight[0]) + longint'(cfg_rate) * e * 256);
            if (nw != longint'(weight[0])) changed = 1'b1;
            weight[0] = nw[W_W-1:0];
            for (int i = 0; i < MAX_FEAT; i++) begin
                xi = longint'($signed(w.x[X_W*i +: X_W]));
                nw = clip32(longint'(weight[i+1])
                            + ((longint'(cfg_rate) * e * xi + 8) >>> UPD_SHIFT));
                if (nw != longint'(weight[i+1])) changed = 1'b1;
                weight[i+1] = nw[W_W-1:0];
            end
        end
        v.decision = dec;
        v.score    = sc[W_W-1:0];
        v.updated  = changed;
        return v;
    endfunction

    task automatic program_reg(input logic idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_MODE) begin
            cfg_mode = value[MODE_W-1:0];
        end else begin
            cfg_rate = value[RATE_W-1:0];
        end
        @(posedge i_clk);
    endtask

    // Offers one word, with an occasional gap in front, and returns at the accepting edge.
    task automatic offer_word(input t_word w);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid     <= 1'b1;
        item_if.action    <= w.action;
        item_if.feature_0 <= w.x[X_W*0 +: X_W];
        item_if.feature_1 <= w.x[X_W*1 +: X_W];
        item_if.feature_2 <= w.x[X_W*2 +: X_W];
        item_if.feature_3 <= w.x[X_W*3 +: X_W];
        item_if.feature_4 <= w.x[X_W*4 +: X_W];
        item_if.feature_5 <= w.x[X_W*5 +: X_W];
        item_if.feature_6 <= w.x[X_W*6 +: X_W];
        item_if.feature_7 <= w.x[X_W*7 +: X_W];
        item_if.label     <= w.label;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        item_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    // A small separable example set, labeled by a random separating plane, is
    // replayed as repeated training passes, with noise words mixed in.
    task automatic run_phase(input int n_items);
        t_word  pool [8];
        int     teacher [MAX_FEAT+1];
        int     pool_n;
        int     pick;
        longint t;
        t_word  w;
        pool_n = $urandom_range(2, 8);
        pick = 0;
        for (int j = 0; j <= MAX_FEAT; j++) teacher[j] = $urandom_range(0, 8) - 4;
        for (int k = 0; k < pool_n; k++) begin
            t = longint'(teacher[0]) * 4096;
            for (int j = 0; j < MAX_FEAT; j++) begin
                case ($urandom_range(0, 9))
                    0: pool[k].x[X_W*j +: X_W] = 16'($urandom);
                    1: pool[k].x[X_W*j +: X_W] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                    default: pool[k].x[X_W*j +: X_W] = 16'($urandom_range(0, 16384)) - 16'd8192;
                endcase
                t += longint'(teacher[j+1]) * longint'($signed(pool[k].x[X_W*j +: X_W]));
            end
            pool[k].action = ACT_TRAIN;
            if (cfg_mode == MODE_ROSENBLATT) begin
                pool[k].label = (t > 0) ? DEC_POS : DEC_ZERO;
            end else begin
                pool[k].label = (t > 0) ? DEC_POS : DEC_NEG;
            end
        end
        for (int made = 0; made < n_items; made++) begin
            if ($urandom_range(0, 6) == 0) begin
                w.action = 1'($urandom);
                w.x      = {$urandom, $urandom, $urandom, $urandom};
                w.label  = 2'($urandom);
            end else begin
                w = pool[pick];
                pick = (pick + 1) % pool_n;
                if ($urandom_range(0, 9) == 0) w.action = ACT_CLASSIFY;
            end
            offer_word(w);
            verdict_q.push_back(classify_and_learn(w));
        end
    endtask

    // Result side: random stalls, one long hold-off on request, none at the end.
    initial begin
        int run;
        int hold_cycles;
        result_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                result_if.ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < HOLD_LEN) begin
                    @(posedge i_clk);
                    hold_cycles++;
                end
                hold_request = 1'b0;
            end else if (quiet) begin
                result_if.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                run = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 10);
                result_if.ready <= ($urandom_range(0, 2) != 0);
                repeat (run) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result word: decision %0d score %0d updated %0b",
                         $time, result_if.decision, result_if.score, result_if.updated);
                failures++;
            end else begin
                want_v = verdict_q.pop_front();
                if (result_if.decision !== want_v.decision) begin
                    $display("%0t: decision expected %0d, got %0d",
                             $time, want_v.decision, result_if.decision);
                    failures++;
                end
                if (result_if.score !== want_v.score) begin
                    $display("%0t: score expected %0d, got %0d",
                             $time, want_v.score, result_if.score);
                    failures++;
                end
                if (result_if.updated !== want_v.updated) begin
                    $display("%0t: updated expected %0b, got %0b",
                             $time, want_v.updated, result_if.updated);
                    failures++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[perceptron_classify_train] ERROR");
        $finish;
    end

    initial begin
        t_word                 w;
        t_verdict              v;
        logic [MODE_W-1:0]     next_mode;
        logic [RATE_W-1:0]     next_rate;
        logic [PDATA_W-1:0]    reg_word;
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        item_if.valid     <= 1'b0;
        item_if.action    <= ACT_CLASSIFY;
        item_if.feature_0 <= '0;
        item_if.feature_1 <= '0;
        item_if.feature_2 <= '0;
        item_if.feature_3 <= '0;
        item_if.feature_4 <= '0;
        item_if.feature_5 <= '0;
        item_if.feature_6 <= '0;
        item_if.feature_7 <= '0;
        item_if.label     <= DEC_ZERO;
        for (int i = 0; i <= MAX_FEAT; i++) weight[i] = '0;
        cfg_mode = MODE_HEAVISIDE;
        cfg_rate = RATE_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].mode != cfg_mode || directed_rows[r].rate != cfg_rate) begin
                drain_results();
                if (directed_rows[r].mode != cfg_mode) begin
                    reg_word = $urandom;
                    reg_word[MODE_W-1:0] = directed_rows[r].mode;
                    program_reg(REG_MODE, reg_word);
                end
                if (directed_rows[r].rate != cfg_rate) begin
                    reg_word = $urandom;
                    reg_word[RATE_W-1:0] = directed_rows[r].rate;
                    program_reg(REG_RATE, reg_word);
                end
            end
            w.action = directed_rows[r].action;
            w.x      = directed_rows[r].x;
            w.label  = directed_rows[r].label;
            offer_word(w);
            v = classify_and_learn(w);
            if (directed_rows[r].known) begin
                v.decision = directed_rows[r].decision;
                v.score    = directed_rows[r].score;
                v.updated  = directed_rows[r].updated;
            end
            verdict_q.push_back(v);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            case (p)
                0: next_mode = MODE_HEAVISIDE;
                1: next_mode = MODE_ROSENBLATT;
                2: next_mode = MODE_REGRESSION;
                3: next_mode = MODE_SPARE;
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: next_mode = MODE_HEAVISIDE;
                        8: next_mode = MODE_REGRESSION;
                        9: next_mode = MODE_SPARE;
                        default: next_mode = MODE_ROSENBLATT;
                    endcase
                end
            endcase
            case ($urandom_range(0, 7))
                0: next_rate = 16'd0;
                1: next_rate = 16'hffff;
                2: next_rate = RATE_RESET;
                default: next_rate = 16'($urandom_range(1, 2047));
            endcase
            reg_word = $urandom;
            reg_word[MODE_W-1:0] = next_mode;
            program_reg(REG_MODE, reg_word);
            reg_word = $urandom;
            reg_word[RATE_W-1:0] = next_rate;
            program_reg(REG_RATE, reg_word);
            if (p == HOLD_PHASE) hold_request = 1'b1;
            if (p >= N_PHASES - 2) quiet = 1'b1;
            run_phase(PHASE_LEN);
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("[perceptron_classify_train] OK");
        end else begin
            $display("[perceptron_classify_train] ERROR");
        end
        $finish;
    end

endmodule
